>>> rtl/core/nmeap_pkg.sv
// Shared types, character codes and layout helpers for the NMEA position parser.
// No dependencies; imported by every module of the block.
`default_nettype none

package nmeap_pkg;

  localparam logic [7:0] CHAR_LF    = 8'h0A;
  localparam logic [7:0] CHAR_START = 8'h24;  // '$'
  localparam logic [7:0] CHAR_COMMA = 8'h2C;
  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_EIGHT = 8'h38;
  localparam logic [7:0] CHAR_A     = 8'h41;
  localparam logic [7:0] CHAR_C     = 8'h43;
  localparam logic [7:0] CHAR_G     = 8'h47;
  localparam logic [7:0] CHAR_L     = 8'h4C;
  localparam logic [7:0] CHAR_M     = 8'h4D;
  localparam logic [7:0] CHAR_R     = 8'h52;
  localparam logic [7:0] CHAR_Z     = 8'h5A;

  localparam int unsigned PosW = 7;
  localparam int unsigned IdxW = 6;

  // characters before the data section: two talker letters and three type letters
  localparam logic [PosW-1:0] TYPE_LEN  = 7'd5;
  localparam logic [PosW-1:0] POS_LIMIT = 7'd65;

  localparam int unsigned TimeN = 13;
  localparam int unsigned LatN  = 10;
  localparam int unsigned LonN  = 11;
  localparam int unsigned DateN = 6;

  typedef enum logic [1:0] {
    KIND_INVALID = 2'd0,
    KIND_GGA     = 2'd1,
    KIND_GLL     = 2'd2,
    KIND_RMC     = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    STATUS_OK     = 2'd0,
    STATUS_FORMAT = 2'd1,
    STATUS_TYPE   = 2'd2
  } status_e;

  typedef struct packed {
    status_e      status;
    kind_e        sentence_kind;
    logic         fix_ok;
    logic [63:0]  time_head;
    logic [39:0]  time_tail;
    logic [63:0]  lat_head;
    logic [7:0]   lat_tail;
    logic [7:0]   lat_hemisphere;
    logic [63:0]  lon_head;
    logic [15:0]  lon_tail;
    logic [7:0]   lon_hemisphere;
    logic [47:0]  date_chars;
  } res_t;

  // required comma positions, by data index
  function automatic logic is_comma(kind_e kind, logic [IdxW-1:0] b);
    logic hit;
    hit = 1'b0;
    unique case (kind)
      KIND_GGA: hit = (b == 6'd0) || (b == 6'd14) || (b == 6'd24) || (b == 6'd26) ||
                      (b == 6'd37) || (b == 6'd39) || (b == 6'd41);
      KIND_GLL: hit = (b == 6'd0) || (b == 6'd10) || (b == 6'd12) || (b == 6'd23) ||
                      (b == 6'd25) || (b == 6'd39) || (b == 6'd41);
      KIND_RMC: hit = (b == 6'd0) || (b == 6'd14) || (b == 6'd16) || (b == 6'd26) ||
                      (b == 6'd28) || (b == 6'd39) || (b == 6'd41) || (b == 6'd47) ||
                      (b == 6'd53);
      KIND_INVALID: hit = 1'b0;
    endcase
    return hit;
  endfunction

  // smallest position count (type plus data) for a complete sentence
  function automatic logic [PosW-1:0] min_pos(kind_e kind);
    logic [PosW-1:0] p;
    p = TYPE_LEN;
    unique case (kind)
      KIND_GGA:     p = 7'd47;
      KIND_GLL:     p = 7'd47;
      KIND_RMC:     p = 7'd65;
      KIND_INVALID: p = TYPE_LEN;
    endcase
    return p;
  endfunction

endpackage

`default_nettype wire

>>> rtl/core/nmeap_char_if.sv
// Character channel: valid/ready handshake carrying one received character per beat.
// No dependencies.
`default_nettype none

interface nmeap_char_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_in;

  modport source (output valid, output char_in, input ready);
  modport sink   (input valid, input char_in, output ready);
endinterface

`default_nettype wire

>>> rtl/core/nmeap_res_if.sv
// Result channel: valid/ready handshake carrying one parsed sentence per beat.
// No dependencies.
`default_nettype none

interface nmeap_res_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [1:0]  sentence_kind;
  logic        fix_ok;
  logic [63:0] time_head;
  logic [39:0] time_tail;
  logic [63:0] lat_head;
  logic [7:0]  lat_tail;
  logic [7:0]  lat_hemisphere;
  logic [63:0] lon_head;
  logic [15:0] lon_tail;
  logic [7:0]  lon_hemisphere;
  logic [47:0] date_chars;

  modport source (output valid, output status, output sentence_kind, output fix_ok,
                  output time_head, output time_tail, output lat_head, output lat_tail,
                  output lat_hemisphere, output lon_head, output lon_tail,
                  output lon_hemisphere, output date_chars, input ready);
  modport sink   (input valid, input status, input sentence_kind, input fix_ok,
                  input time_head, input time_tail, input lat_head, input lat_tail,
                  input lat_hemisphere, input lon_head, input lon_tail,
                  input lon_hemisphere, input date_chars, output ready);
endinterface

`default_nettype wire

>>> rtl/core/nmeap_parse.sv
// Sentence state and field capture: updates parser state per character and forms
// the result on line feed. Depends on nmeap_pkg.
`default_nettype none

module nmeap_parse
  import nmeap_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       char_valid_i,
  input  wire logic [7:0] char_i,
  output logic            res_valid_o,
  output res_t            res_o
);

  logic            in_sent_q, in_sent_d;
  logic [PosW-1:0] pos_q, pos_d;
  kind_e           kind_q, kind_d;
  logic            type_inv_q, type_inv_d;
  logic            comma_q, comma_d;
  logic            fix_q, fix_d;

  logic [7:0] tc0_q, tc0_d, tc1_q, tc1_d;
  logic [7:0] time_q [TimeN];
  logic [7:0] time_d [TimeN];
  logic [7:0] lat_q  [LatN];
  logic [7:0] lat_d  [LatN];
  logic [7:0] lon_q  [LonN];
  logic [7:0] lon_d  [LonN];
  logic [7:0] date_q [DateN];
  logic [7:0] date_d [DateN];

  logic            bad;
  kind_e           kind_new;
  logic [IdxW-1:0] b;
  logic [PosW-1:0] b_full;

  assign b_full = pos_q - TYPE_LEN;
  assign b      = b_full[IdxW-1:0];

  always_comb begin
    in_sent_d   = in_sent_q;
    pos_d       = pos_q;
    kind_d      = kind_q;
    type_inv_d  = type_inv_q;
    comma_d     = comma_q;
    fix_d       = fix_q;
    tc0_d       = tc0_q;
    tc1_d       = tc1_q;
    time_d      = time_q;
    lat_d       = lat_q;
    lon_d       = lon_q;
    date_d      = date_q;
    bad         = 1'b0;
    kind_new    = KIND_INVALID;
    res_valid_o = 1'b0;
    res_o       = '0;

    if (char_valid_i) begin
      if (char_i == CHAR_START) begin
        in_sent_d  = 1'b1;
        pos_d      = '0;
        kind_d     = KIND_INVALID;
        type_inv_d = 1'b0;
        comma_d    = 1'b0;
        fix_d      = 1'b0;
      end else if (in_sent_q && (char_i != CHAR_LF)) begin
        if (pos_q < POS_LIMIT) begin
          pos_d = pos_q + 7'd1;
          if (pos_q < TYPE_LEN) begin
            if (pos_q <= 7'd1) begin
              bad = !((char_i >= CHAR_A) && (char_i <= CHAR_Z));
            end else if (pos_q == 7'd2) begin
              bad   = (char_i != CHAR_G) && (char_i != CHAR_R);
              tc0_d = char_i;
            end else if (pos_q == 7'd3) begin
              bad   = !(((char_i == CHAR_G) && (tc0_q == CHAR_G)) ||
                        ((char_i == CHAR_L) && (tc0_q == CHAR_G)) ||
                        ((char_i == CHAR_M) && (tc0_q == CHAR_R)));
              tc1_d = char_i;
            end else begin
              if ((char_i == CHAR_A) && (tc1_q == CHAR_G)) kind_new = KIND_GGA;
              else if ((char_i == CHAR_L) && (tc1_q == CHAR_L)) kind_new = KIND_GLL;
              else if ((char_i == CHAR_C) && (tc1_q == CHAR_M)) kind_new = KIND_RMC;
              if (kind_new == KIND_INVALID) bad = 1'b1;
              else if (!type_inv_q) kind_d = kind_new;
            end
            if (bad) begin
              type_inv_d = 1'b1;
              kind_d     = KIND_INVALID;
            end
          end else if (!type_inv_q) begin
            if (is_comma(kind_q, b)) begin
              if (char_i != CHAR_COMMA) comma_d = 1'b1;
            end else begin
              unique case (kind_q)
                KIND_GGA: begin
                  for (int i = 0; i < TimeN; i++) if (b == 6'(1 + i)) time_d[i] = char_i;
                  for (int i = 0; i < 9; i++) if (b == 6'(15 + i)) lat_d[i] = char_i;
                  if (b == 6'd25) lat_d[9] = char_i;
                  for (int i = 0; i < 10; i++) if (b == 6'(27 + i)) lon_d[i] = char_i;
                  if (b == 6'd38) lon_d[10] = char_i;
                  if (b == 6'd40) fix_d = (char_i > CHAR_ZERO) && (char_i < CHAR_EIGHT);
                end
                KIND_GLL: begin
                  for (int i = 0; i < 9; i++) if (b == 6'(1 + i)) lat_d[i] = char_i;
                  if (b == 6'd11) lat_d[9] = char_i;
                  for (int i = 0; i < 10; i++) if (b == 6'(13 + i)) lon_d[i] = char_i;
                  if (b == 6'd24) lon_d[10] = char_i;
                  for (int i = 0; i < TimeN; i++) if (b == 6'(26 + i)) time_d[i] = char_i;
                  if (b == 6'd40) fix_d = (char_i == CHAR_A);
                end
                KIND_RMC: begin
                  for (int i = 0; i < TimeN; i++) if (b == 6'(1 + i)) time_d[i] = char_i;
                  if (b == 6'd15) fix_d = (char_i == CHAR_A);
                  for (int i = 0; i < 9; i++) if (b == 6'(17 + i)) lat_d[i] = char_i;
                  if (b == 6'd27) lat_d[9] = char_i;
                  for (int i = 0; i < 10; i++) if (b == 6'(29 + i)) lon_d[i] = char_i;
                  if (b == 6'd40) lon_d[10] = char_i;
                  for (int i = 0; i < DateN; i++) if (b == 6'(54 + i)) date_d[i] = char_i;
                end
                KIND_INVALID: ;
              endcase
            end
          end
        end
      end else if (in_sent_q) begin
        in_sent_d           = 1'b0;
        res_valid_o         = 1'b1;
        res_o.sentence_kind = kind_q;
        if (type_inv_q || (kind_q == KIND_INVALID)) begin
          res_o.status = STATUS_TYPE;
        end else if (comma_q || (pos_q < min_pos(kind_q))) begin
          res_o.status = STATUS_FORMAT;
        end else begin
          res_o.status         = STATUS_OK;
          res_o.fix_ok         = fix_q;
          res_o.time_head      = {time_q[0], time_q[1], time_q[2], time_q[3],
                                  time_q[4], time_q[5], time_q[6], time_q[7]};
          res_o.time_tail      = {time_q[8], time_q[9], time_q[10], time_q[11], time_q[12]};
          res_o.lat_head       = {lat_q[0], lat_q[1], lat_q[2], lat_q[3],
                                  lat_q[4], lat_q[5], lat_q[6], lat_q[7]};
          res_o.lat_tail       = lat_q[8];
          res_o.lat_hemisphere = lat_q[9];
          res_o.lon_head       = {lon_q[0], lon_q[1], lon_q[2], lon_q[3],
                                  lon_q[4], lon_q[5], lon_q[6], lon_q[7]};
          res_o.lon_tail       = {lon_q[8], lon_q[9]};
          res_o.lon_hemisphere = lon_q[10];
          if (kind_q == KIND_RMC) begin
            res_o.date_chars = {date_q[0], date_q[1], date_q[2],
                                date_q[3], date_q[4], date_q[5]};
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_sent_q  <= 1'b0;
      pos_q      <= '0;
      kind_q     <= KIND_INVALID;
      type_inv_q <= 1'b0;
      comma_q    <= 1'b0;
      fix_q      <= 1'b0;
    end else begin
      in_sent_q  <= in_sent_d;
      pos_q      <= pos_d;
      kind_q     <= kind_d;
      type_inv_q <= type_inv_d;
      comma_q    <= comma_d;
      fix_q      <= fix_d;
    end
  end

  // every field of an ok sentence is rewritten after its '$', so no reset here
  always_ff @(posedge clk_i) begin
    tc0_q  <= tc0_d;
    tc1_q  <= tc1_d;
    time_q <= time_d;
    lat_q  <= lat_d;
    lon_q  <= lon_d;
    date_q <= date_d;
  end

endmodule

`default_nettype wire

>>> rtl/core/nmea_position_sentence_parser.sv
// Top level of the NMEA GGA/GLL/RMC position parser: input register, parser, result register.
// Depends on nmeap_pkg, nmeap_char_if, nmeap_res_if and nmeap_parse.
//
//   port    dir   beat
//   in_i    in    one received character (char_in)
//   res_o   out   one parsed sentence, given on each line feed inside a sentence
//
// One character per cycle while the result is not stalled. A line feed that is accepted
// waits in the input register while the parser feeds the result register, and its result
// is valid once it is registered there. Reset clears the sentence state and both valid
// flags. A stalled result holds the pipe; the input register still takes one more character.
`default_nettype none

module nmea_position_sentence_parser
  import nmeap_pkg::*;
(
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  nmeap_char_if.sink    in_i,
  nmeap_res_if.source   res_o
);

  logic       in_valid_q;
  logic [7:0] in_char_q;
  logic       res_valid_q;
  res_t       res_q;
  logic       adv;
  logic       fire;
  res_t       res;

  assign adv        = !res_valid_q || res_o.ready;
  assign in_i.ready = !in_valid_q || adv;

  nmeap_parse u_parse (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .char_valid_i(in_valid_q && adv),
    .char_i      (in_char_q),
    .res_valid_o (fire),
    .res_o       (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      res_valid_q <= 1'b0;
    end else begin
      if (in_i.ready) in_valid_q <= in_i.valid;
      if (adv) res_valid_q <= in_valid_q && fire;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) in_char_q <= in_i.char_in;
    if (adv && in_valid_q && fire) res_q <= res;
  end

  assign res_o.valid          = res_valid_q;
  assign res_o.status         = res_q.status;
  assign res_o.sentence_kind  = res_q.sentence_kind;
  assign res_o.fix_ok         = res_q.fix_ok;
  assign res_o.time_head      = res_q.time_head;
  assign res_o.time_tail      = res_q.time_tail;
  assign res_o.lat_head       = res_q.lat_head;
  assign res_o.lat_tail       = res_q.lat_tail;
  assign res_o.lat_hemisphere = res_q.lat_hemisphere;
  assign res_o.lon_head       = res_q.lon_head;
  assign res_o.lon_tail       = res_q.lon_tail;
  assign res_o.lon_hemisphere = res_q.lon_hemisphere;
  assign res_o.date_chars     = res_q.date_chars;

endmodule

`default_nettype wire

>>> verif/nmea_position_sentence_parser_tb.sv
// Testbench for nmea_position_sentence_parser: GGA/GLL/RMC sentences and noise in, results checked.
// Depends on nmeap_pkg, nmeap_char_if, nmeap_res_if and the parser RTL.
module nmea_position_sentence_parser_tb;
  import nmeap_pkg::*;

  typedef struct packed {
    logic       drain;
    logic [7:0] ch;
  } char_item_t;

  localparam logic [63:0] GGA_COMMAS = (64'd1 << 0) | (64'd1 << 14) | (64'd1 << 24) |
                                       (64'd1 << 26) | (64'd1 << 37) | (64'd1 << 39) |
                                       (64'd1 << 41);
  localparam logic [63:0] GLL_COMMAS = (64'd1 << 0) | (64'd1 << 10) | (64'd1 << 12) |
                                       (64'd1 << 23) | (64'd1 << 25) | (64'd1 << 39) |
                                       (64'd1 << 41);
  localparam logic [63:0] RMC_COMMAS = (64'd1 << 0) | (64'd1 << 14) | (64'd1 << 16) |
                                       (64'd1 << 26) | (64'd1 << 28) | (64'd1 << 39) |
                                       (64'd1 << 41) | (64'd1 << 47) | (64'd1 << 53);
  localparam int MAX_IDLE = 13;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  nmeap_char_if char_if ();
  nmeap_res_if  res_if ();

  nmea_position_sentence_parser u_top (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .in_i   (char_if.sink),
    .res_o  (res_if.source)
  );

  char_item_t char_q [$];
  res_t       sentence_q [$];
  char_item_t item;
  res_t       want;

  logic       char_taken = 1'b0;
  logic       res_taken = 1'b0;
  int         tx_wait = 0;
  int         rx_wait = 0;
  bit         tx_idle = 1'b1;
  bit         rx_idle = 1'b1;
  int         fail_cnt = 0;
  int         chars_in = 0;
  int         n_ok = 0;
  int         n_format = 0;
  int         n_type = 0;
  int         planned_chars = 0;
  int         planned_lines = 0;

  // sentence tracking state
  bit         sent_open = 1'b0;
  int         sent_pos = 0;
  kind_e      sent_kind = KIND_INVALID;
  bit         kind_bad = 1'b0;
  logic [7:0] type_ltr [2];
  bit         comma_bad = 1'b0;
  bit         fix_seen = 1'b0;
  logic [7:0] time_b [TimeN];
  logic [7:0] lat_b [LatN];
  logic [7:0] lon_b [LonN];
  logic [7:0] date_b [DateN];

  task automatic note_mismatch(input string what, input logic [63:0] got,
                               input logic [63:0] want_v);
    fail_cnt++;
    $display("MISMATCH %s: got %h, expected %h", what, got, want_v);
  endtask

  task automatic track_char(input logic [7:0] c);
    logic [63:0] cmask;
    int          min_len;
    int          b;
    int          dlen;
    bit          bad;
    kind_e       k;
    res_t        sent_r;
    case (sent_kind)
      KIND_GGA: begin cmask = GGA_COMMAS; min_len = 42; end
      KIND_GLL: begin cmask = GLL_COMMAS; min_len = 42; end
      KIND_RMC: begin cmask = RMC_COMMAS; min_len = 60; end
      default:  begin cmask = '0; min_len = 0; end
    endcase
    if (c == CHAR_START) begin
      sent_open = 1'b1;
      sent_pos = 0;
      sent_kind = KIND_INVALID;
      kind_bad = 1'b0;
      type_ltr[0] = '0;
      type_ltr[1] = '0;
      comma_bad = 1'b0;
      fix_seen = 1'b0;
      foreach (time_b[i]) time_b[i] = '0;
      foreach (lat_b[i]) lat_b[i] = '0;
      foreach (lon_b[i]) lon_b[i] = '0;
      foreach (date_b[i]) date_b[i] = '0;
    end else if (sent_open && c != CHAR_LF) begin
      if (sent_pos < 65) begin
        if (sent_pos < 5) begin
          bad = 1'b0;
          k = KIND_INVALID;
          case (sent_pos)
            0, 1: bad = !(c >= CHAR_A && c <= CHAR_Z);
            2: begin
              bad = (c != CHAR_G && c != CHAR_R);
              type_ltr[0] = c;
            end
            3: begin
              bad = !((c == CHAR_G && type_ltr[0] == CHAR_G) ||
                      (c == CHAR_L && type_ltr[0] == CHAR_G) ||
                      (c == CHAR_M && type_ltr[0] == CHAR_R));
              type_ltr[1] = c;
            end
            default: begin
              if (c == CHAR_A && type_ltr[1] == CHAR_G) k = KIND_GGA;
              else if (c == CHAR_L && type_ltr[1] == CHAR_L) k = KIND_GLL;
              else if (c == CHAR_C && type_ltr[1] == CHAR_M) k = KIND_RMC;
              if (k == KIND_INVALID) bad = 1'b1;
              else if (!kind_bad) sent_kind = k;
            end
          endcase
          if (bad) begin
            kind_bad = 1'b1;
            sent_kind = KIND_INVALID;
          end
        end else if (!kind_bad) begin
          b = sent_pos - 5;
          if (cmask[b]) begin
            if (c != CHAR_COMMA) comma_bad = 1'b1;
          end else begin
            case (sent_kind)
              KIND_GGA: begin
                if (b >= 1 && b <= 13) time_b[b-1] = c;
                else if (b >= 15 && b <= 23) lat_b[b-15] = c;
                else if (b == 25) lat_b[9] = c;
                else if (b >= 27 && b <= 36) lon_b[b-27] = c;
                else if (b == 38) lon_b[10] = c;
                else if (b == 40) fix_seen = (c > CHAR_ZERO && c < CHAR_EIGHT);
              end
              KIND_GLL: begin
                if (b >= 1 && b <= 9) lat_b[b-1] = c;
                else if (b == 11) lat_b[9] = c;
                else if (b >= 13 && b <= 22) lon_b[b-13] = c;
                else if (b == 24) lon_b[10] = c;
                else if (b >= 26 && b <= 38) time_b[b-26] = c;
                else if (b == 40) fix_seen = (c == CHAR_A);
              end
              KIND_RMC: begin
                if (b >= 1 && b <= 13) time_b[b-1] = c;
                else if (b == 15) fix_seen = (c == CHAR_A);
                else if (b >= 17 && b <= 25) lat_b[b-17] = c;
                else if (b == 27) lat_b[9] = c;
                else if (b >= 29 && b <= 38) lon_b[b-29] = c;
                else if (b == 40) lon_b[10] = c;
                else if (b >= 54 && b <= 59) date_b[b-54] = c;
              end
              default: begin end
            endcase
          end
        end
        sent_pos++;
      end
    end else if (sent_open) begin
      sent_open = 1'b0;
      dlen = (sent_pos >= 5) ? sent_pos - 5 : 0;
      sent_r = '0;
      sent_r.sentence_kind = sent_kind;
      if (kind_bad || sent_kind == KIND_INVALID) sent_r.status = STATUS_TYPE;
      else if (comma_bad || dlen < min_len) sent_r.status = STATUS_FORMAT;
      else begin
        sent_r.status = STATUS_OK;
        sent_r.fix_ok = fix_seen;
        for (int i = 0; i < 8; i++) begin
          sent_r.time_head = {sent_r.time_head[55:0], time_b[i]};
          sent_r.lat_head = {sent_r.lat_head[55:0], lat_b[i]};
          sent_r.lon_head = {sent_r.lon_head[55:0], lon_b[i]};
        end
        for (int i = 0; i < 5; i++) sent_r.time_tail = {sent_r.time_tail[31:0], time_b[8+i]};
        sent_r.lat_tail = lat_b[8];
        sent_r.lat_hemisphere = lat_b[9];
        sent_r.lon_tail = {lon_b[8], lon_b[9]};
        sent_r.lon_hemisphere = lon_b[10];
        if (sent_kind == KIND_RMC) begin
          for (int i = 0; i < 6; i++) sent_r.date_chars = {sent_r.date_chars[39:0], date_b[i]};
        end
      end
      sentence_q.push_back(sent_r);
    end
  endtask

  function automatic logic [7:0] field_char();
    logic [7:0] c;
    do begin
      if ($urandom_range(0, 3) == 0) c = 8'($urandom_range(0, 255));
      else c = 8'($urandom_range(8'h20, 8'h7E));
    end while (c == CHAR_START || c == CHAR_LF);
    return c;
  endfunction

  task automatic push_char(input logic [7:0] c, input bit drain);
    char_item_t it;
    it.ch = c;
    it.drain = drain;
    char_q.push_back(it);
  endtask

  task automatic push_text(input string s);
    for (int i = 0; i < s.len(); i++) push_char(s[i], 1'b0);
  endtask

  task automatic push_sentence(input kind_e k, input bit drain);
    logic [7:0]  tag [5];
    logic [63:0] cmask;
    logic [7:0]  c;
    int          dlen;
    int          n;
    int          fix_at;
    int          broken;
    int          len_mode;
    tag[0] = 8'($urandom_range(CHAR_A, CHAR_Z));
    tag[1] = 8'($urandom_range(CHAR_A, CHAR_Z));
    case (k)
      KIND_GGA: begin
        tag[2] = CHAR_G; tag[3] = CHAR_G; tag[4] = CHAR_A;
        cmask = GGA_COMMAS; dlen = 42; fix_at = 40;
      end
      KIND_GLL: begin
        tag[2] = CHAR_G; tag[3] = CHAR_L; tag[4] = CHAR_L;
        cmask = GLL_COMMAS; dlen = 42; fix_at = 40;
      end
      KIND_RMC: begin
        tag[2] = CHAR_R; tag[3] = CHAR_M; tag[4] = CHAR_C;
        cmask = RMC_COMMAS; dlen = 60; fix_at = 15;
      end
      default: begin
        for (int i = 2; i < 5; i++) tag[i] = 8'($urandom_range(CHAR_A, CHAR_Z));
        cmask = '0; dlen = $urandom_range(0, 45); fix_at = -1;
      end
    endcase
    if ($urandom_range(0, 9) == 0) tag[$urandom_range(0, 4)] = field_char();
    len_mode = $urandom_range(0, 7);
    if (len_mode == 0 && dlen > 0) n = $urandom_range(0, dlen - 1);
    else if (len_mode == 1) n = dlen + $urandom_range(1, 30);
    else n = dlen;
    broken = -1;
    if (cmask != '0 && $urandom_range(0, 7) == 0) begin
      do broken = $urandom_range(0, dlen - 1); while (!cmask[broken]);
    end
    push_char(CHAR_START, drain);
    for (int i = 0; i < 5; i++) push_char(tag[i], 1'b0);
    for (int b = 0; b < n; b++) begin
      if (b < 64 && cmask[b]) begin
        c = CHAR_COMMA;
        if (b == broken) while (c == CHAR_COMMA) c = field_char();
      end else if (b == fix_at) begin
        case ($urandom_range(0, 5))
          0: c = CHAR_ZERO;
          1: c = "1";
          2: c = "7";
          3: c = CHAR_EIGHT;
          4: c = CHAR_A;
          default: c = field_char();
        endcase
      end else begin
        c = field_char();
      end
      push_char(c, 1'b0);
    end
    planned_chars += 6 + n;
    if ($urandom_range(0, 19) != 0) begin
      push_char(CHAR_LF, 1'b0);
      planned_chars++;
      planned_lines++;
    end
  endtask

  // driver
  always @(negedge clk) begin
    if (!rst_n) begin
      char_if.valid <= 1'b0;
      char_if.char_in <= '0;
    end else if (char_if.valid && !char_taken) begin
      // beat still pending
    end else if (tx_wait > 0) begin
      char_if.valid <= 1'b0;
      tx_wait--;
    end else if (char_q.size() == 0 || (char_q[0].drain && sentence_q.size() != 0)) begin
      char_if.valid <= 1'b0;
    end else begin
      item = char_q.pop_front();
      char_if.valid <= 1'b1;
      char_if.char_in <= item.ch;
      if ($urandom_range(0, 39) == 0) tx_idle = !tx_idle;
      tx_wait = tx_idle ? $urandom_range(0, MAX_IDLE) : 0;
    end
  end

  // result sink
  always @(negedge clk) begin
    if (!rst_n) begin
      res_if.ready <= 1'b0;
    end else begin
      if (res_taken) begin
        if ($urandom_range(0, 39) == 0) rx_idle = !rx_idle;
        rx_wait = rx_idle ? $urandom_range(0, MAX_IDLE) : 0;
      end
      if (rx_wait > 0) begin
        res_if.ready <= 1'b0;
        rx_wait--;
      end else begin
        res_if.ready <= 1'b1;
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    if (!rst_n) begin
      char_taken <= 1'b0;
      res_taken <= 1'b0;
    end else begin
      char_taken <= char_if.valid && char_if.ready;
      res_taken <= res_if.valid && res_if.ready;
      if (char_if.valid && char_if.ready) begin
        chars_in++;
        track_char(char_if.char_in);
      end
      if (res_if.valid && res_if.ready) begin
        if (sentence_q.size() == 0) begin
          note_mismatch("result with nothing pending", 64'(res_if.status), '0);
        end else begin
          want = sentence_q.pop_front();
          case (want.status)
            STATUS_OK:     n_ok++;
            STATUS_FORMAT: n_format++;
            default:       n_type++;
          endcase
          if (res_if.status !== want.status)
            note_mismatch("status", 64'(res_if.status), 64'(want.status));
          if (res_if.sentence_kind !== want.sentence_kind)
            note_mismatch("sentence_kind", 64'(res_if.sentence_kind),
                          64'(want.sentence_kind));
          if (res_if.fix_ok !== want.fix_ok)
            note_mismatch("fix_ok", 64'(res_if.fix_ok), 64'(want.fix_ok));
          if (res_if.time_head !== want.time_head)
            note_mismatch("time_head", res_if.time_head, want.time_head);
          if (res_if.time_tail !== want.time_tail)
            note_mismatch("time_tail", 64'(res_if.time_tail), 64'(want.time_tail));
          if (res_if.lat_head !== want.lat_head)
            note_mismatch("lat_head", res_if.lat_head, want.lat_head);
          if (res_if.lat_tail !== want.lat_tail)
            note_mismatch("lat_tail", 64'(res_if.lat_tail), 64'(want.lat_tail));
          if (res_if.lat_hemisphere !== want.lat_hemisphere)
            note_mismatch("lat_hemisphere", 64'(res_if.lat_hemisphere),
                          64'(want.lat_hemisphere));
          if (res_if.lon_head !== want.lon_head)
            note_mismatch("lon_head", res_if.lon_head, want.lon_head);
          if (res_if.lon_tail !== want.lon_tail)
            note_mismatch("lon_tail", 64'(res_if.lon_tail), 64'(want.lon_tail));
          if (res_if.lon_hemisphere !== want.lon_hemisphere)
            note_mismatch("lon_hemisphere", 64'(res_if.lon_hemisphere),
                          64'(want.lon_hemisphere));
          if (res_if.date_chars !== want.date_chars)
            note_mismatch("date_chars", 64'(res_if.date_chars), 64'(want.date_chars));
        end
      end
    end
  end

  initial begin
    int  r;
    int  nz;
    bit  drained;
    char_if.valid = 1'b0;
    char_if.char_in = '0;
    res_if.ready = 1'b0;

    // outside a sentence, empty sentence, restart, short GGA, bad talker, bad type tail
    push_char(8'h00, 1'b0);
    push_char(8'hFF, 1'b0);
    push_char(CHAR_LF, 1'b0);
    push_char(CHAR_START, 1'b0);
    push_char(CHAR_LF, 1'b0);
    push_text("$GP$GPGGA\n");
    push_text("$1PRMC\n");
    push_text("$GNRMA\n");

    drained = 1'b0;
    while (planned_chars < 1300 || planned_lines < 20) begin
      if ($urandom_range(0, 3) == 0) begin
        nz = $urandom_range(1, 4);
        repeat (nz) push_char(8'($urandom_range(0, 255)), 1'b0);
        planned_chars += nz;
      end
      r = $urandom_range(0, 9);
      push_sentence((r == 0) ? KIND_INVALID : (r < 4) ? KIND_GGA : (r < 7) ? KIND_GLL : KIND_RMC,
                    !drained && planned_chars >= 600);
      if (planned_chars >= 600) drained = 1'b1;
    end

    repeat (6) @(negedge clk);
    rst_n <= 1'b1;

    while (char_q.size() != 0 || char_if.valid) @(negedge clk);
    while (sentence_q.size() != 0) @(negedge clk);
    repeat (8) @(negedge clk);

    $display("Took %0d chars; checked %0d sentences: %0d ok, %0d format, %0d unknown type.",
             chars_in, n_ok + n_format + n_type, n_ok, n_format, n_type);
    if (fail_cnt == 0 && sentence_q.size() == 0) begin
      $display("nmea_position_sentence_parser verification clean");
    end else begin
      $display("nmea_position_sentence_parser verification failed");
    end
    $finish;
  end

  initial begin
    #1000000;
    $display("nmea_position_sentence_parser verification failed");
    $finish;
  end

endmodule
